// ----- sv/cpip_pkg.sv -----
// shared types, constants and arithmetic helpers for the chroma plane predictor
package cpip_pkg;

  // working width of plane sums; holds every intermediate pixel value in two's complement
  localparam int PW = 16;
  // width of one edge gradient (H or V), ten times a byte difference
  localparam int GW = 13;
  // bits of one half row: four columns of interleaved U,V bytes
  localparam int HALF_W = 64;
  localparam int EDGE_W = 2 * HALF_W;
  localparam int NUM_CH = 2;
  localparam logic [2:0] LAST_ROW = 3'd7;

  typedef logic [PW-1:0] pw_t;

  // per-channel plane coefficients, base already folds in -3b, -3c and rounding
  typedef struct packed {
    pw_t base;
    pw_t slope_x;
    pw_t slope_y;
  } plane_coef_t;

  typedef plane_coef_t [NUM_CH-1:0] plane_coef_arr_t;

  // one byte of an edge, sample idx 0..7 of channel ch
  function automatic logic [7:0] edge_sample(input logic [EDGE_W-1:0] e, input logic [2:0] idx,
                                             input logic ch);
    return e[{idx, ch, 3'b000} +: 8];
  endfunction

  // sum (k+1)*(e[4+k]-e[2-k]) with the corner at index -1
  function automatic logic [GW-1:0] edge_grad(input logic [EDGE_W-1:0] e, input logic [7:0] corner,
                                              input logic ch);
    logic [GW-1:0] d1;
    logic [GW-1:0] d2;
    logic [GW-1:0] d3;
    logic [GW-1:0] d4;
    d1 = {5'b0, edge_sample(e, 3'd4, ch)} - {5'b0, edge_sample(e, 3'd2, ch)};
    d2 = {5'b0, edge_sample(e, 3'd5, ch)} - {5'b0, edge_sample(e, 3'd1, ch)};
    d3 = {5'b0, edge_sample(e, 3'd6, ch)} - {5'b0, edge_sample(e, 3'd0, ch)};
    d4 = {5'b0, edge_sample(e, 3'd7, ch)} - {5'b0, corner};
    return d1 + (d2 << 1) + (d3 << 1) + d3 + (d4 << 2);
  endfunction

  // (34*g + 32) >>> 6, sign extended to the working width
  function automatic pw_t plane_slope(input logic [GW-1:0] g);
    logic [18:0] g_ext;
    logic [18:0] t;
    g_ext = {{6{g[GW-1]}}, g};
    t = (g_ext << 5) + (g_ext << 1) + 19'd32;
    return {{3{t[18]}}, t[18:6]};
  endfunction

  // (s >>> 5) clipped to 0..255
  function automatic logic [7:0] clip_pixel(input pw_t s);
    logic [7:0] p;
    if (s[PW-1]) begin
      p = 8'd0;
    end else if (|s[PW-2:13]) begin
      p = 8'd255;
    end else begin
      p = s[12:5];
    end
    return p;
  endfunction

endpackage

// ----- sv/cpip_coef.sv -----
// plane coefficient calculation from the registered neighbour samples
module cpip_coef (
  input  logic [63:0]               top_first_half,
  input  logic [63:0]               top_second_half,
  input  logic [63:0]               left_upper_half,
  input  logic [63:0]               left_lower_half,
  input  logic [15:0]               corner_pair,
  output cpip_pkg::plane_coef_arr_t coef
);
  import cpip_pkg::*;

  logic [EDGE_W-1:0] top_edge;
  logic [EDGE_W-1:0] left_edge;

  assign top_edge  = {top_second_half, top_first_half};
  assign left_edge = {left_lower_half, left_upper_half};

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic [7:0] corner_s;
    logic [8:0] dc_sum;
    pw_t        a_val;
    pw_t        b_val;
    pw_t        c_val;

    assign corner_s = corner_pair[ch*8 +: 8];
    assign dc_sum   = {1'b0, edge_sample(left_edge, 3'd7, 1'(ch))} +
                      {1'b0, edge_sample(top_edge, 3'd7, 1'(ch))};
    assign a_val    = {3'b0, dc_sum, 4'b0};
    assign b_val    = plane_slope(edge_grad(top_edge, corner_s, 1'(ch)));
    assign c_val    = plane_slope(edge_grad(left_edge, corner_s, 1'(ch)));

    // value of the top-left pixel before the final shift
    assign coef[ch].base    = a_val - (b_val << 1) - b_val - (c_val << 1) - c_val + pw_t'(16);
    assign coef[ch].slope_x = b_val;
    assign coef[ch].slope_y = c_val;
  end

endmodule

// ----- sv/cpip_row_gen.sv -----
// row generator: walks the eight rows of a block and holds the result register
module cpip_row_gen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      coef_valid,
  output logic                      coef_ready,
  input  cpip_pkg::plane_coef_arr_t coef,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_row_number,
  output logic [63:0]               out_row_left_half,
  output logic [63:0]               out_row_right_half,
  output logic                      out_final_row
);
  import cpip_pkg::*;

  logic                    act_r;
  logic                    act_nxt;
  logic [2:0]              row_r;
  logic [NUM_CH-1:0][PW-1:0] acc_r;
  logic [NUM_CH-1:0][PW-1:0] bx_r;
  logic [NUM_CH-1:0][PW-1:0] cy_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [2:0]              out_row_r;
  logic [63:0]             out_left_r;
  logic [63:0]             out_right_r;
  logic                    out_final_r;
  logic                    emit;
  logic                    last;
  logic                    take;
  logic [EDGE_W-1:0]       row_bits;

  assign emit       = act_r && (!out_valid_r || out_ready);
  assign last       = (row_r == LAST_ROW);
  assign coef_ready = !act_r || (emit && last);
  assign take       = coef_valid && coef_ready;

  // eight columns of both channels for the current row
  always_comb begin
    row_bits = '0;
    for (int x = 0; x < 8; x++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        row_bits[(x*2+ch)*8 +: 8] = clip_pixel(acc_r[ch] + pw_t'(x) * bx_r[ch]);
      end
    end
  end

  always_comb begin
    act_nxt = act_r;
    if (take) begin
      act_nxt = 1'b1;
    end else if (emit && last) begin
      act_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
      if (take) begin
        row_r <= '0;
      end else if (emit) begin
        row_r <= row_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (take) begin
        acc_r[ch] <= coef[ch].base;
        bx_r[ch]  <= coef[ch].slope_x;
        cy_r[ch]  <= coef[ch].slope_y;
      end else if (emit) begin
        acc_r[ch] <= acc_r[ch] + cy_r[ch];
      end
    end
    if (emit) begin
      out_row_r   <= row_r;
      out_left_r  <= row_bits[HALF_W-1:0];
      out_right_r <= row_bits[EDGE_W-1:HALF_W];
      out_final_r <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_number     = out_row_r;
  assign out_row_left_half  = out_left_r;
  assign out_row_right_half = out_right_r;
  assign out_final_row      = out_final_r;

`ifndef SYNTHESIS
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> (act_r && row_r == $past(row_r) + 3'd1))
    else $error("row counter did not advance within a block");

  a_acc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> (acc_r[0] == $past(acc_r[0]) + $past(cy_r[0])))
    else $error("row accumulator did not advance by the vertical slope");

  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_final_row) |=>
      (!out_valid || out_row_number == $past(out_row_number) + 3'd1))
    else $error("rows of a block left out of order");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && act_r) |-> (emit && last))
    else $error("new block loaded over an unfinished one");
`endif

endmodule

// ----- sv/chroma_plane_intra_predictor.sv -----
// top level of the 8x8 chroma plane-mode intra predictor
//
// usage:
// - input channel (in_*): one request per 8x8 chroma block, carrying the
//   eight interleaved U/V neighbours above, the eight to the left (top
//   to bottom) and the top-left corner pair
// - result channel (out_*): eight requests per block, one predicted row
//   each, row 0 first; out_final_row marks row 7
// - a block is captured in an input register, its plane coefficients are
//   formed from that register and loaded into the row generator, which
//   emits one row per cycle into the output register unless stalled
// - order: a block goes through the input register, the row generator's
//   coefficient registers and then the output register; later rows follow
//   one per cycle unless stalled; the next block waits in the input
//   register while the current one drains, so rows of consecutive blocks
//   go out without gaps
// - stall: while out_ready is low and a row is waiting, the output register
//   holds its row and the row generator pauses; in_ready drops once the
//   input register is full and the row generator cannot take it
// - reset: synchronous, active low; clears all valid flags, no block is
//   in flight afterwards
module chroma_plane_intra_predictor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_top_first_half,
  input  logic [63:0] in_top_second_half,
  input  logic [63:0] in_left_upper_half,
  input  logic [63:0] in_left_lower_half,
  input  logic [15:0] in_corner_pair,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row_number,
  output logic [63:0] out_row_left_half,
  output logic [63:0] out_row_right_half,
  output logic        out_final_row
);
  import cpip_pkg::*;

  // input register
  logic            hold_valid_r;
  logic            hold_valid_nxt;
  logic [63:0]     top_lo_r;
  logic [63:0]     top_hi_r;
  logic [63:0]     left_lo_r;
  logic [63:0]     left_hi_r;
  logic [15:0]     corner_r;
  logic            in_take;
  logic            coef_ready;
  plane_coef_arr_t coef;

  // free the input register as soon as the row generator loads it
  assign in_ready = !hold_valid_r || coef_ready;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_take) begin
      hold_valid_nxt = 1'b1;
    end else if (coef_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      top_lo_r  <= in_top_first_half;
      top_hi_r  <= in_top_second_half;
      left_lo_r <= in_left_upper_half;
      left_hi_r <= in_left_lower_half;
      corner_r  <= in_corner_pair;
    end
  end

  // gradients, slopes and top-left base for both channels
  cpip_coef u_coef (
    .top_first_half  (top_lo_r),
    .top_second_half (top_hi_r),
    .left_upper_half (left_lo_r),
    .left_lower_half (left_hi_r),
    .corner_pair     (corner_r),
    .coef            (coef)
  );

  // one row per cycle unless out_ready stalls it, held in the output register
  cpip_row_gen u_row_gen (
    .clk                (clk),
    .rst_n              (rst_n),
    .coef_valid         (hold_valid_r),
    .coef_ready         (coef_ready),
    .coef               (coef),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_number     (out_row_number),
    .out_row_left_half  (out_row_left_half),
    .out_row_right_half (out_row_right_half),
    .out_final_row      (out_final_row)
  );

`ifndef SYNTHESIS
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && !coef_ready) |-> !in_ready)
    else $error("input request taken over a pending block");

  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && !coef_ready) |=> (hold_valid_r && $stable(corner_r) && $stable(top_lo_r)))
    else $error("pending block lost before the row generator took it");

  // row 0 goes out right after the load unless the previous row is still held
  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && coef_ready) |=> ##1
      (out_valid && (out_row_number == 3'd0 || !$past(out_ready))))
    else $error("first row of a loaded block not presented");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the chroma 8x8 plane-mode intra predictor
module tb;

  // idle and stall percentages per phase: receiver-heavy first, sender-heavy next, then none
  localparam int NUM_DIRECTED = 15;
  localparam int NUM_RANDOM   = 320;
  localparam int PHASE_LEN    = 110;
  // the long receiver hold-off starts once this many requests went in, during the no-idle phase
  localparam int HOLD_AT      = NUM_DIRECTED + 2 * PHASE_LEN + 20;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [63:0] ZERO    = 64'h0000_0000_0000_0000;
  localparam logic [63:0] ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MID     = 64'h8080_8080_8080_8080;
  localparam logic [63:0] U_ONLY  = 64'h00FF_00FF_00FF_00FF;
  localparam logic [63:0] V_ONLY  = 64'hFF00_FF00_FF00_FF00;
  localparam logic [63:0] CHECK_A = 64'hAA55_AA55_AA55_AA55;
  localparam logic [63:0] CHECK_B = 64'h55AA_55AA_55AA_55AA;

  // one predicted row as it leaves the block
  typedef struct {
    logic [2:0]  row;
    logic [63:0] left_half;
    logic [63:0] right_half;
    logic        last;
  } plane_row_t;

  // one directed request; fill_known marks blocks whose every pixel is one obvious value
  typedef struct packed {
    logic [63:0] top0;
    logic [63:0] top1;
    logic [63:0] left0;
    logic [63:0] left1;
    logic [15:0] corner;
    logic        fill_known;
    logic [7:0]  fill;
  } plane_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_top_first_half = '0;
  logic [63:0] in_top_second_half = '0;
  logic [63:0] in_left_upper_half = '0;
  logic [63:0] in_left_lower_half = '0;
  logic [15:0] in_corner_pair = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_row_number;
  logic [63:0] out_row_left_half;
  logic [63:0] out_row_right_half;
  logic        out_final_row;

  // rows still owed by the block, oldest first
  plane_row_t expected_rows [$];
  plane_row_t head_row;

  int blocks_taken = 0;
  int rows_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 68;
  int hold_left = 0;
  bit hold_done = 1'b0;

  chroma_plane_intra_predictor u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_top_first_half  (in_top_first_half),
    .in_top_second_half (in_top_second_half),
    .in_left_upper_half (in_left_upper_half),
    .in_left_lower_half (in_left_lower_half),
    .in_corner_pair     (in_corner_pair),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_number     (out_row_number),
    .out_row_left_half  (out_row_left_half),
    .out_row_right_half (out_row_right_half),
    .out_final_row      (out_final_row)
  );

  // 12-unit clock period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one neighbour sample along an edge; index -1 is the corner pair
  function automatic int edge_px(input logic [127:0] e, input logic [15:0] corner, input int idx,
                                 input int ch);
    if (idx < 0) begin
      return {24'd0, corner[ch*8 +: 8]};
    end
    return {24'd0, e[idx*16 + ch*8 +: 8]};
  endfunction

  // plane prediction of one block, queues its eight rows
  function automatic void predict_plane_rows(input logic [127:0] top_e, input logic [127:0] left_e,
                                             input logic [15:0] corner);
    int grad_h;
    int grad_v;
    int pix;
    int plane_a [2];
    int slope_b [2];
    int slope_c [2];
    logic [127:0] row_bits;
    plane_row_t r;
    for (int ch = 0; ch < 2; ch++) begin
      grad_h = 0;
      grad_v = 0;
      for (int k = 0; k < 4; k++) begin
        grad_h += (k + 1) * (edge_px(top_e, corner, 4 + k, ch) -
                             edge_px(top_e, corner, 2 - k, ch));
        grad_v += (k + 1) * (edge_px(left_e, corner, 4 + k, ch) -
                             edge_px(left_e, corner, 2 - k, ch));
      end
      plane_a[ch] = 16 * (edge_px(left_e, corner, 7, ch) + edge_px(top_e, corner, 7, ch));
      // int is signed, so >>> floors like the arithmetic shift of the spec
      slope_b[ch] = (34 * grad_h + 32) >>> 6;
      slope_c[ch] = (34 * grad_v + 32) >>> 6;
    end
    for (int y = 0; y < 8; y++) begin
      row_bits = '0;
      for (int x = 0; x < 8; x++) begin
        for (int ch = 0; ch < 2; ch++) begin
          pix = (plane_a[ch] + slope_b[ch] * (x - 3) + slope_c[ch] * (y - 3) + 16) >>> 5;
          if (pix < 0) begin
            pix = 0;
          end else if (pix > 255) begin
            pix = 255;
          end
          row_bits[x*16 + ch*8 +: 8] = pix[7:0];
        end
      end
      r.row = y[2:0];
      r.left_half = row_bits[63:0];
      r.right_half = row_bits[127:64];
      r.last = (y == 7);
      expected_rows.push_back(r);
    end
  endfunction

  // offer one block, with random idle cycles first, and book its rows once taken
  task automatic offer_block(input logic [63:0] t0, input logic [63:0] t1, input logic [63:0] l0,
                             input logic [63:0] l1, input logic [15:0] cr, input bit fill_known,
                             input logic [7:0] fill);
    plane_row_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_top_first_half <= t0;
    in_top_second_half <= t1;
    in_left_upper_half <= l0;
    in_left_lower_half <= l1;
    in_corner_pair <= cr;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    // request taken at this edge; valid stays up until the next call decides
    blocks_taken++;
    if (fill_known) begin
      for (int y = 0; y < 8; y++) begin
        r.row = y[2:0];
        r.left_half = {8{fill}};
        r.right_half = {8{fill}};
        r.last = (y == 7);
        expected_rows.push_back(r);
      end
    end else begin
      predict_plane_rows({t1, t0}, {l1, l0}, cr);
    end
  endtask

  // stimulus: reset, directed table, then random blocks over three idle phases
  initial begin
    plane_case_t dir_tab [NUM_DIRECTED];
    logic [127:0] top_e;
    logic [127:0] left_e;
    logic [15:0] corner;
    int base;
    int dx;
    int dy;
    int s;
    dir_tab = '{
      // flat black and white planes, and mid gray
      '{ZERO, ZERO, ZERO, ZERO, 16'h0000, 1'b1, 8'h00},
      '{ONES, ONES, ONES, ONES, 16'hFFFF, 1'b1, 8'hFF},
      '{MID, MID, MID, MID, 16'h8080, 1'b1, 8'h80},
      // steepest rising and falling top edge
      '{ZERO, ONES, ZERO, ZERO, 16'h0000, 1'b0, 8'h00},
      '{ONES, ZERO, ZERO, ZERO, 16'hFFFF, 1'b0, 8'h00},
      // steepest rising and falling left edge
      '{ZERO, ZERO, ZERO, ONES, 16'h0000, 1'b0, 8'h00},
      '{ZERO, ZERO, ONES, ZERO, 16'hFFFF, 1'b0, 8'h00},
      // both gradients at their positive and negative extremes
      '{ZERO, ONES, ZERO, ONES, 16'h0000, 1'b0, 8'h00},
      '{ONES, ZERO, ONES, ZERO, 16'hFFFF, 1'b0, 8'h00},
      // corner alone, then corner U only
      '{ZERO, ZERO, ZERO, ZERO, 16'hFFFF, 1'b0, 8'h00},
      '{ZERO, ZERO, ZERO, ZERO, 16'h00FF, 1'b0, 8'h00},
      // one chroma channel saturated, the other dark
      '{U_ONLY, U_ONLY, U_ONLY, U_ONLY, 16'h00FF, 1'b0, 8'h00},
      '{V_ONLY, V_ONLY, V_ONLY, V_ONLY, 16'hFF00, 1'b0, 8'h00},
      // checkerboard and a byte ramp
      '{CHECK_A, CHECK_B, CHECK_B, CHECK_A, 16'h55AA, 1'b0, 8'h00},
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h1032_5476_98BA_DCFE,
        64'hEFCD_AB89_6745_2301, 16'h7F80, 1'b0, 8'h00}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_block(dir_tab[i].top0, dir_tab[i].top1, dir_tab[i].left0, dir_tab[i].left1,
                  dir_tab[i].corner, dir_tab[i].fill_known, dir_tab[i].fill);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == PHASE_LEN) begin
        send_idle_pct = 68;
        recv_idle_pct = 33;
      end else if (n == 2 * PHASE_LEN) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(1) == 0) begin
        // arbitrary bytes: mostly saturated pixels
        top_e = {$urandom, $urandom, $urandom, $urandom};
        left_e = {$urandom, $urandom, $urandom, $urandom};
        corner = 16'($urandom_range(16'hFFFF));
      end else begin
        // smooth ramps with a little noise, the way real neighbours look
        for (int ch = 0; ch < 2; ch++) begin
          base = $urandom_range(255);
          dx = int'($urandom_range(40)) - 20;
          dy = int'($urandom_range(40)) - 20;
          for (int i = -1; i < 8; i++) begin
            s = base + dx * (i - 3) + int'($urandom_range(6)) - 3;
            s = (s < 0) ? 0 : (s > 255) ? 255 : s;
            if (i < 0) begin
              corner[ch*8 +: 8] = s[7:0];
            end else begin
              top_e[i*16 + ch*8 +: 8] = s[7:0];
            end
            s = base + dy * (i - 3) + int'($urandom_range(6)) - 3;
            s = (s < 0) ? 0 : (s > 255) ? 255 : s;
            if (i >= 0) begin
              left_e[i*16 + ch*8 +: 8] = s[7:0];
            end
          end
        end
      end
      offer_block(top_e[63:0], top_e[127:64], left_e[63:0], left_e[127:64], corner, 1'b0, 8'h00);
    end
    in_valid <= 1'b0;

    // let every owed row come out, then watch for strays
    while (expected_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d blocks (%0d from the directed table), %0d rows compared",
             blocks_taken, NUM_DIRECTED, rows_checked);
    $display("idle phases on both sides plus a %0d-cycle output hold-off, %0d mismatches",
             HOLD_LEN, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: random stalls per phase, plus one long hold-off that backs the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && blocks_taken >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each taken row with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row %0d, nothing owed", $time, out_row_number);
        error_count++;
      end else begin
        head_row = expected_rows.pop_front();
        rows_checked++;
        if (out_row_number !== head_row.row) begin
          $display("%0t: row number expected %0d got %0d", $time, head_row.row, out_row_number);
          error_count++;
        end
        if (out_row_left_half !== head_row.left_half) begin
          $display("%0t: row %0d left half expected %h got %h", $time, head_row.row,
                   head_row.left_half, out_row_left_half);
          error_count++;
        end
        if (out_row_right_half !== head_row.right_half) begin
          $display("%0t: row %0d right half expected %h got %h", $time, head_row.row,
                   head_row.right_half, out_row_right_half);
          error_count++;
        end
        if (out_final_row !== head_row.last) begin
          $display("%0t: row %0d final flag expected %b got %b", $time, head_row.row,
                   head_row.last, out_final_row);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still owed", cycle_count,
               expected_rows.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
